### src/ansi_escape_sequence_decoder_defines.svh
// Assertion macros for the escape sequence decoder
`ifndef ANSI_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ANSI_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define AESD_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define AESD_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

### src/aesd_pkg.sv
// ----------------------------------------------------------------------------
// aesd_pkg
// Types and codes shared by the escape sequence decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aesd_pkg;

    localparam int unsigned POS_W = 14;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_PUT     = 3'd1,
        ACT_NEWLINE = 3'd2,
        ACT_ERASE_EOL = 3'd3,
        ACT_DELETE  = 3'd4,
        ACT_ERASE_SCR = 3'd5,
        ACT_REPORT  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SEC  = 3'd1,
        PH_OSCP = 3'd2,
        PH_OSCS = 3'd3,
        PH_CSIP = 3'd4,
        PH_CSII = 3'd5
    } t_phase;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_QM  = 8'h3F;

    // parser state carried from one character to the next
    typedef struct packed {
        t_phase           phase;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [4:0]       fg;
        logic [4:0]       bg;
        logic [1:0]       style;
        logic [POS_W-1:0] acc;
        logic [POS_W-1:0] first;
        logic [1:0]       cnt;
        logic             priv;
        logic             bad;
        logic             dig;
        logic             lz;
        logic             any;
        logic [4:0]       pfg;
        logic [4:0]       pbg;
    } t_state;

    typedef struct packed {
        t_action          action;
        logic [7:0]       out_char;
        logic [POS_W-1:0] action_row;
        logic [POS_W-1:0] action_col;
        logic [POS_W-1:0] cursor_row;
        logic [POS_W-1:0] cursor_col;
        logic [4:0]       fg_code;
        logic [4:0]       bg_code;
        logic [1:0]       cursor_style;
        logic             scrolled;
    } t_result;

endpackage

### src/aesd_step.sv
// ----------------------------------------------------------------------------
// aesd_step
// Next-state and result logic for one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aesd_step #(
    parameter int unsigned POS_MAX = 9999
) (
    input  logic [7:0]       i_char,
    input  logic [7:0]       i_rows,
    input  aesd_pkg::t_state i_st,
    output aesd_pkg::t_state o_st,
    output aesd_pkg::t_result o_res
);

    localparam logic [13:0] PMAX = 14'(POS_MAX);

    logic [13:0] v;
    logic [13:0] rows14;
    logic [13:0] rlim;
    logic [17:0] acc10;
    logic        single;

    function automatic logic [9:0] sgr(input logic [13:0] p, input logic [4:0] f,
                                       input logic [4:0] b);
        logic [4:0] nf;
        logic [4:0] nb;
        nf = f;
        nb = b;
        if (p == 14'd0) begin
            nf = 5'd0;
            nb = 5'd0;
        end else if (p >= 14'd30 && p <= 14'd37) begin
            nf = 5'(p - 14'd29);
        end else if (p >= 14'd90 && p <= 14'd97) begin
            nf = 5'(p - 14'd81);
        end else if (p >= 14'd40 && p <= 14'd47) begin
            nb = 5'(p - 14'd39);
        end else if (p >= 14'd100 && p <= 14'd107) begin
            nb = 5'(p - 14'd91);
        end
        return {nb, nf};
    endfunction

    // exact text match: no separators, only digits, leading '?' exactly as pv asks
    function automatic logic text_is(input aesd_pkg::t_state s, input logic pv,
                                     input logic [13:0] want);
        return s.cnt == 2'd0 && s.priv == pv && !s.bad && s.dig && !s.lz
            && s.acc == want;
    endfunction

    assign rows14 = {6'd0, i_rows};
    assign rlim   = (i_rows != 8'd0) ? rows14 - 14'd1 : 14'd0;
    assign single = (i_st.cnt == 2'd0);
    assign v      = (i_st.bad || (i_st.priv && single)) ? 14'd0 : i_st.acc;
    assign acc10  = {4'd0, i_st.acc} * 18'd10 + {14'd0, i_char[3:0]};

    always_comb begin
        logic [9:0] pc;
        o_st  = i_st;
        o_res = '0;
        o_res.action     = aesd_pkg::ACT_NONE;
        o_res.action_row = i_st.row;
        o_res.action_col = i_st.col;
        pc = '0;
        if (i_char == aesd_pkg::CH_CR) begin
            // dropped
        end else if (i_char == aesd_pkg::CH_LF) begin
            o_res.action = aesd_pkg::ACT_NEWLINE;
            if ({1'b0, i_st.row} + 15'd1 >= {7'd0, i_rows}) o_res.scrolled = 1'b1;
            else o_st.row = i_st.row + 14'd1;
            o_st.col = '0;
        end else begin
            unique case (i_st.phase)
                aesd_pkg::PH_SEC: begin
                    if (i_char == 8'h5B) begin
                        o_st.phase = aesd_pkg::PH_CSIP;
                        o_st.acc = '0;
                        o_st.first = '0;
                        {o_st.cnt, o_st.priv, o_st.bad, o_st.dig, o_st.lz, o_st.any} = '0;
                        o_st.pfg = i_st.fg;
                        o_st.pbg = i_st.bg;
                    end else if (i_char == 8'h5D) begin
                        o_st.phase = aesd_pkg::PH_OSCP;
                    end else begin
                        o_st.phase = aesd_pkg::PH_IDLE;
                    end
                end
                aesd_pkg::PH_OSCP: begin
                    if (i_char == aesd_pkg::CH_SEMI) o_st.phase = aesd_pkg::PH_OSCS;
                end
                aesd_pkg::PH_OSCS: begin
                    if (i_char == aesd_pkg::CH_BEL) o_st.phase = aesd_pkg::PH_IDLE;
                end
                aesd_pkg::PH_CSIP, aesd_pkg::PH_CSII: begin
                    if (i_st.phase == aesd_pkg::PH_CSIP && i_char >= 8'h30
                        && i_char <= 8'h3F) begin
                        if (i_char <= 8'h39) begin
                            if (i_st.dig && i_st.acc == 14'd0) o_st.lz = 1'b1;
                            o_st.acc = (acc10 > {4'd0, PMAX}) ? PMAX : acc10[13:0];
                            o_st.dig = 1'b1;
                        end else if (i_char == aesd_pkg::CH_SEMI) begin
                            if (single) o_st.first = v;
                            pc = sgr(v, i_st.pfg, i_st.pbg);
                            o_st.pfg = pc[4:0];
                            o_st.pbg = pc[9:5];
                            if (i_st.cnt != 2'd3) o_st.cnt = i_st.cnt + 2'd1;
                            o_st.bad = 1'b0;
                            o_st.dig = 1'b0;
                            o_st.lz  = 1'b0;
                            o_st.acc = '0;
                        end else if (i_char == aesd_pkg::CH_QM && !i_st.any) begin
                            o_st.priv = 1'b1;
                        end else begin
                            o_st.bad = 1'b1;
                        end
                        o_st.any = 1'b1;
                    end else if (i_char >= 8'h20 && i_char <= 8'h2F) begin
                        o_st.phase = aesd_pkg::PH_CSII;
                    end else begin
                        o_st.phase = aesd_pkg::PH_IDLE;
                        unique case (i_char)
                            8'h6D: begin // m
                                pc = sgr(v, i_st.pfg, i_st.pbg);
                                o_st.pfg = pc[4:0];
                                o_st.pbg = pc[9:5];
                                o_st.fg  = pc[4:0];
                                o_st.bg  = pc[9:5];
                            end
                            8'h41: begin // A
                                if (i_st.row != 14'd0) o_st.row = i_st.row - 14'd1;
                                o_st.col = '0;
                            end
                            8'h42: begin // B
                                o_st.row = (i_st.row + 14'd1 < rlim) ?
                                    i_st.row + 14'd1 : rlim;
                                o_st.col = '0;
                            end
                            8'h43: if (i_st.col < PMAX) o_st.col = i_st.col + 14'd1;
                            8'h44: if (i_st.col != 14'd0) o_st.col = i_st.col - 14'd1;
                            8'h4A: begin // J
                                if (single && v == 14'd2) begin
                                    o_res.action = aesd_pkg::ACT_ERASE_SCR;
                                    if (i_rows != 8'd0) begin
                                        if (i_st.row < rlim) o_st.row = rlim;
                                        o_st.col = '0;
                                        o_res.scrolled = 1'b1;
                                    end
                                end
                            end
                            8'h4B: if (!single || v == 14'd0)
                                o_res.action = aesd_pkg::ACT_ERASE_EOL;
                            8'h50: o_res.action = aesd_pkg::ACT_DELETE;
                            8'h68: if (text_is(i_st, 1'b1, 14'd25)
                                    || text_is(i_st, 1'b1, 14'd12)) o_st.style = 2'd2;
                            8'h6C: begin
                                if (text_is(i_st, 1'b1, 14'd25)) o_st.style = 2'd0;
                                else if (text_is(i_st, 1'b1, 14'd12)) o_st.style = 2'd1;
                            end
                            8'h48: begin // H
                                if (i_st.cnt == 2'd1) begin
                                    o_st.row = (i_st.first != 14'd0) ?
                                        i_st.first - 14'd1 : 14'd0;
                                    o_st.col = (v != 14'd0) ? v - 14'd1 : 14'd0;
                                end
                            end
                            8'h6E: if (text_is(i_st, 1'b0, 14'd6))
                                o_res.action = aesd_pkg::ACT_REPORT;
                            default: ;
                        endcase
                    end
                end
                default: begin
                    o_st.phase = aesd_pkg::PH_IDLE;
                    if (i_char == aesd_pkg::CH_ESC) begin
                        o_st.phase = aesd_pkg::PH_SEC;
                    end else if (i_char == aesd_pkg::CH_BEL) begin
                        // swallowed
                    end else if (i_char == aesd_pkg::CH_BS) begin
                        if (i_st.col != 14'd0) o_st.col = i_st.col - 14'd1;
                    end else begin
                        o_res.action   = aesd_pkg::ACT_PUT;
                        o_res.out_char = i_char;
                        if (i_st.col < PMAX) o_st.col = i_st.col + 14'd1;
                    end
                end
            endcase
        end
        o_res.cursor_row   = o_st.row;
        o_res.cursor_col   = o_st.col;
        o_res.fg_code      = o_st.fg;
        o_res.bg_code      = o_st.bg;
        o_res.cursor_style = o_st.style;
    end

endmodule

### src/ansi_escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// ansi_escape_sequence_decoder
// VT100 / ANSI escape parser: one command per character.
// ----------------------------------------------------------------------------
// Decoding is combinational: the parser state and the result register are
// updated at the edge that accepts the request, so one character per clock
// is sustained while i_ready is high. One output register holds the result;
// a new request is taken whenever that register is empty or being drained.
`timescale 1ns / 1ps

module ansi_escape_sequence_decoder #(
    parameter int unsigned POS_MAX = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_out_char,
    output logic [13:0] o_action_row,
    output logic [13:0] o_action_col,
    output logic [13:0] o_cursor_row,
    output logic [13:0] o_cursor_col,
    output logic [4:0]  o_fg_code,
    output logic [4:0]  o_bg_code,
    output logic [1:0]  o_cursor_style,
    output logic        o_scrolled
);

    // idle, cursor home, default colours, steady cursor
    localparam aesd_pkg::t_state ST_RESET = '{
        phase: aesd_pkg::PH_IDLE, row: '0, col: '0, fg: '0, bg: '0, style: 2'd1,
        acc: '0, first: '0, cnt: '0, priv: 1'b0, bad: 1'b0, dig: 1'b0, lz: 1'b0,
        any: 1'b0, pfg: '0, pbg: '0
    };

    aesd_pkg::t_state  r_st, n_st;
    aesd_pkg::t_result r_res, n_res;
    logic [7:0]        r_rows;
    logic              r_valid;
    logic              w_acc;

    aesd_step #(.POS_MAX(POS_MAX)) u_step (
        .i_char (i_char_code),
        .i_rows (r_rows),
        .i_st   (r_st),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_RESET;
            r_rows     <= 8'd24;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) r_rows <= i_cfg_data;
            if (w_acc) r_st <= n_st;
            if (w_acc) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_res <= n_res;
    end

    assign o_valid        = r_valid;
    assign o_action       = r_res.action;
    assign o_out_char     = r_res.out_char;
    assign o_action_row   = r_res.action_row;
    assign o_action_col   = r_res.action_col;
    assign o_cursor_row   = r_res.cursor_row;
    assign o_cursor_col   = r_res.cursor_col;
    assign o_fg_code      = r_res.fg_code;
    assign o_bg_code      = r_res.bg_code;
    assign o_cursor_style = r_res.cursor_style;
    assign o_scrolled     = r_res.scrolled;

endmodule

### src/aesd_checker.sv
// ----------------------------------------------------------------------------
// aesd_checker
// Port-level checks for the escape sequence decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ansi_escape_sequence_decoder_defines.svh"

module aesd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_action,
    input logic [7:0]  o_out_char,
    input logic [1:0]  o_cursor_style,
    input logic        o_scrolled
);

    `AESD_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready, "ready low while empty")
    `AESD_ASSERT_NXT(a_req_shows, i_clk, i_rst_n, i_valid && o_ready, o_valid, "request lost")
    `AESD_ASSERT_IMP(a_char_zero, i_clk, i_rst_n, o_valid && o_action != aesd_pkg::ACT_PUT, o_out_char == 8'd0, "char without put")
    `AESD_ASSERT_IMP(a_scroll_act, i_clk, i_rst_n, o_valid && o_scrolled, o_action == aesd_pkg::ACT_NEWLINE || o_action == aesd_pkg::ACT_ERASE_SCR, "stray scroll")
    `AESD_ASSERT_IMP(a_style, i_clk, i_rst_n, o_valid, o_cursor_style != 2'd3, "bad style")

endmodule

bind ansi_escape_sequence_decoder aesd_checker u_aesd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_action       (o_action),
    .o_out_char     (o_out_char),
    .o_cursor_style (o_cursor_style),
    .o_scrolled     (o_scrolled)
);

### test/tb_decoder_checker.sv
// ----------------------------------------------------------------------------
// tb_decoder_checker
// Watches the character and command channels of the escape sequence decoder,
// predicts each command from its own copy of the parser state and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_out_char,
    input  logic [13:0] i_action_row,
    input  logic [13:0] i_action_col,
    input  logic [13:0] i_cursor_row,
    input  logic [13:0] i_cursor_col,
    input  logic [4:0]  i_fg_code,
    input  logic [4:0]  i_bg_code,
    input  logic [1:0]  i_cursor_style,
    input  logic        i_scrolled,
    output int          o_errors,
    output int          o_pending
);

    localparam int LIMIT = 9999;

    aesd_pkg::t_result cmd_queue[$];
    aesd_pkg::t_phase  phase;
    int      rows, row, col, fg, bg, style, acc, first, cnt;
    bit      priv, bad, dig, lz, any;
    int      pfg, pbg;

    function automatic int field_val();
        if (bad) return 0;
        if (priv && cnt == 0) return 0;
        return acc;
    endfunction

    function automatic bit text_match(bit want_priv, int v);
        return cnt == 0 && priv == want_priv && !bad && dig && !lz && acc == v;
    endfunction

    function automatic void sgr_update(int p);
        if (p == 0) begin
            pfg = 0;
            pbg = 0;
        end else if (p >= 30 && p <= 37) pfg = p - 29;
        else if (p >= 90 && p <= 97) pfg = p - 81;
        else if (p >= 40 && p <= 47) pbg = p - 39;
        else if (p >= 100 && p <= 107) pbg = p - 91;
    endfunction

    function automatic void newline_move(ref bit scr);
        if (row + 1 >= rows) scr = 1;
        else row++;
        col = 0;
    endfunction

    function automatic aesd_pkg::t_action run_final(int c, ref bit scr);
        int      v;
        bit      single;
        aesd_pkg::t_action act;
        v = field_val();
        single = (cnt == 0);
        act = aesd_pkg::ACT_NONE;
        case (c)
            "m": begin
                sgr_update(v);
                fg = pfg;
                bg = pbg;
            end
            "A": begin
                if (row > 0) row--;
                col = 0;
            end
            "B": begin
                row = (row + 1 < ((rows > 0) ? rows - 1 : 0)) ? row + 1
                    : ((rows > 0) ? rows - 1 : 0);
                col = 0;
            end
            "C": if (col < LIMIT) col++;
            "D": if (col > 0) col--;
            "J": if (single && v == 2) begin
                act = aesd_pkg::ACT_ERASE_SCR;
                if (rows > 0) begin
                    if (row < rows - 1) row = rows - 1;
                    col = 0;
                    scr = 1;
                end
            end
            "K": if (!single || v == 0) act = aesd_pkg::ACT_ERASE_EOL;
            "P": act = aesd_pkg::ACT_DELETE;
            "h": if (text_match(1, 25) || text_match(1, 12)) style = 2;
            "l": begin
                if (text_match(1, 25)) style = 0;
                else if (text_match(1, 12)) style = 1;
            end
            "H": if (cnt == 1) begin
                row = (first > 0) ? first - 1 : 0;
                col = (v > 0) ? v - 1 : 0;
            end
            "n": if (text_match(0, 6)) act = aesd_pkg::ACT_REPORT;
            default: ;
        endcase
        return act;
    endfunction

    function automatic aesd_pkg::t_result decode_char(int c);
        aesd_pkg::t_result r;
        bit      scr;
        int      v;
        scr = 0;
        r = '0;
        r.action = aesd_pkg::ACT_NONE;
        r.action_row = 14'(row);
        r.action_col = 14'(col);
        if (c == aesd_pkg::CH_CR) begin
        end else if (c == aesd_pkg::CH_LF) begin
            r.action = aesd_pkg::ACT_NEWLINE;
            newline_move(scr);
        end else begin
            case (phase)
                aesd_pkg::PH_SEC: begin
                    if (c == "[") begin
                        phase = aesd_pkg::PH_CSIP;
                        acc = 0; first = 0; cnt = 0;
                        {priv, bad, dig, lz, any} = '0;
                        pfg = fg;
                        pbg = bg;
                    end else if (c == "]") phase = aesd_pkg::PH_OSCP;
                    else phase = aesd_pkg::PH_IDLE;
                end
                aesd_pkg::PH_OSCP: if (c == aesd_pkg::CH_SEMI) phase = aesd_pkg::PH_OSCS;
                aesd_pkg::PH_OSCS: if (c == aesd_pkg::CH_BEL) phase = aesd_pkg::PH_IDLE;
                aesd_pkg::PH_CSIP, aesd_pkg::PH_CSII: begin
                    if (phase == aesd_pkg::PH_CSIP && c >= 8'h30 && c <= 8'h3F) begin
                        if (c <= 8'h39) begin
                            if (dig && acc == 0) lz = 1;
                            acc = acc * 10 + (c - 8'h30);
                            if (acc > LIMIT) acc = LIMIT;
                            dig = 1;
                        end else if (c == aesd_pkg::CH_SEMI) begin
                            v = field_val();
                            if (cnt == 0) first = v;
                            sgr_update(v);
                            if (cnt < 3) cnt++;
                            bad = 0; dig = 0; lz = 0;
                            acc = 0;
                        end else if (c == aesd_pkg::CH_QM && !any) priv = 1;
                        else bad = 1;
                        any = 1;
                    end else if (c >= 8'h20 && c <= 8'h2F) begin
                        phase = aesd_pkg::PH_CSII;
                    end else begin
                        r.action = run_final(c, scr);
                        phase = aesd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase = aesd_pkg::PH_IDLE;
                    if (c == aesd_pkg::CH_ESC) phase = aesd_pkg::PH_SEC;
                    else if (c == aesd_pkg::CH_BEL) begin
                    end else if (c == aesd_pkg::CH_BS) begin
                        if (col > 0) col--;
                    end else begin
                        r.action = aesd_pkg::ACT_PUT;
                        r.out_char = 8'(c);
                        if (col < LIMIT) col++;
                    end
                end
            endcase
        end
        r.cursor_row = 14'(row);
        r.cursor_col = 14'(col);
        r.fg_code = 5'(fg);
        r.bg_code = 5'(bg);
        r.cursor_style = 2'(style);
        r.scrolled = scr;
        return r;
    endfunction

    always @(posedge i_clk) begin
        aesd_pkg::t_result got, want;
        if (!i_rst_n) begin
            cmd_queue.delete();
            o_errors <= 0;
            rows = 24; phase = aesd_pkg::PH_IDLE; row = 0; col = 0; fg = 0; bg = 0;
            style = 1;
            acc = 0; first = 0; cnt = 0; {priv, bad, dig, lz, any} = '0;
            pfg = 0; pbg = 0;
        end else begin
            if (i_cfg_we) rows = i_cfg_data;
            if (i_valid && i_in_ready) cmd_queue.push_back(decode_char(i_char_code));
            if (i_out_valid && i_ready) begin
                got = {aesd_pkg::t_action'(i_action), i_out_char, i_action_row,
                       i_action_col, i_cursor_row, i_cursor_col, i_fg_code, i_bg_code,
                       i_cursor_style, i_scrolled};
                if (cmd_queue.size() == 0) begin
                    $display("%0t: command with none expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = cmd_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= cmd_queue.size();
    end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives character streams and rows settings into the escape sequence
// decoder with random bursts and stalls; the checker judges the commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_char_code = 0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_action;
    logic [7:0]  o_out_char;
    logic [13:0] o_action_row, o_action_col, o_cursor_row, o_cursor_col;
    logic [4:0]  o_fg_code, o_bg_code;
    logic [1:0]  o_cursor_style;
    logic        o_scrolled;
    int          errors, pending;
    int          idle_cycles = 0;
    int          hold_off = 0;
    bit          long_stall = 0;
    byte         char_stream[$];

    always #2 i_clk = ~i_clk;

    ansi_escape_sequence_decoder i_dut (.*);

    tb_decoder_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_char_code,
        .i_cfg_we, .i_cfg_data, .i_out_valid(o_valid), .i_ready,
        .i_action(o_action), .i_out_char(o_out_char), .i_action_row(o_action_row),
        .i_action_col(o_action_col), .i_cursor_row(o_cursor_row),
        .i_cursor_col(o_cursor_col), .i_fg_code(o_fg_code), .i_bg_code(o_bg_code),
        .i_cursor_style(o_cursor_style), .i_scrolled(o_scrolled),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: own stall pattern, plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 0;
        end else if (long_stall) begin
            hold_off <= 300;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic put_text(string s);
        for (int k = 0; k < s.len(); k++) char_stream.push_back(s[k]);
    endtask

    function automatic byte param_char();
        int p;
        p = $urandom_range(0, 19);
        if (p < 12) return byte'("0" + $urandom_range(0, 9));
        if (p < 16) return aesd_pkg::CH_SEMI;
        if (p < 18) return aesd_pkg::CH_QM;
        return byte'(8'h3A + $urandom_range(0, 5));
    endfunction

    task automatic random_sequence();
        string finals;
        int    n;
        finals = "mABCDJKPhlHnqz@";
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                char_stream.push_back(aesd_pkg::CH_ESC);
                char_stream.push_back("[");
                n = $urandom_range(0, 6);
                case ($urandom_range(0, 4))
                    0: put_text($sformatf("%0d", $urandom_range(0, 107)));
                    1: put_text($sformatf("%0d;%0d", $urandom_range(0, 40),
                                          $urandom_range(0, 120)));
                    2: put_text($urandom_range(0, 1) ? "?25" : "?12");
                    default: repeat (n) char_stream.push_back(param_char());
                endcase
                if ($urandom_range(0, 9) == 0)
                    char_stream.push_back(byte'(8'h20 + $urandom_range(0, 15)));
                if ($urandom_range(0, 15) == 0) char_stream.push_back(aesd_pkg::CH_LF);
                char_stream.push_back(finals[$urandom_range(0, finals.len() - 1)]);
            end
            4: begin
                put_text("\033]0;");
                repeat ($urandom_range(0, 5))
                    char_stream.push_back(byte'($urandom_range(32, 126)));
                char_stream.push_back(aesd_pkg::CH_BEL);
            end
            5: char_stream.push_back(byte'($urandom_range(0, 255)));
            6: char_stream.push_back($urandom_range(0, 1) ? aesd_pkg::CH_LF
                                                          : aesd_pkg::CH_CR);
            default: repeat ($urandom_range(1, 4))
                char_stream.push_back(byte'($urandom_range(32, 126)));
        endcase
    endtask

    task automatic send_stream();
        byte c;
        int  burst;
        burst = 0;
        while (char_stream.size() > 0) begin
            if (burst == 0) begin
                i_valid <= 0;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(posedge i_clk);
                burst = $urandom_range(1, 30);
            end
            c = char_stream.pop_front();
            i_valid <= 1;
            i_char_code <= c;
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            burst--;
        end
        i_valid <= 0;
    endtask

    task automatic drain();
        repeat (2) @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_rows(int r);
        i_cfg_we <= 1;
        i_cfg_data <= 8'(r);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        int rows_list[5] = '{24, 1, 255, 3, 128};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: controls, SGR extremes, modes, report, home, erase, delete, column clamp, OSC
        put_text("A\010\010\007\r\n\377");
        char_stream.push_back(8'h00);
        put_text("\033[31;44m\033[97;107m\033[0m");
        put_text("\033[?25l\033[?12h\033[?25h\033[6n\033[3;5H\033[2J\033[K\033[P");
        put_text("\033[99999C\033[1;2K\033]x;y\033\007");
        send_stream();
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            set_rows(rows_list[ph]);
            for (int k = 0; k < 70; k++) random_sequence();
            send_stream();
            if (ph == 1) begin
                // back up the receiver while input keeps coming
                long_stall <= 1;
                @(posedge i_clk);
                long_stall <= 0;
                for (int k = 0; k < 40; k++) random_sequence();
                send_stream();
            end
            drain();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/aesd_pkg.sv
src/aesd_step.sv
src/ansi_escape_sequence_decoder.sv
src/aesd_checker.sv
test/tb_decoder_checker.sv
test/tb_top.sv
